FILE: src/fda_pkg.sv
// ----------------------------------------------------------------------------
// fda_pkg
// Shared types, widths and helpers for the fractional delay allpass.
// ----------------------------------------------------------------------------
package fda_pkg;

  localparam int SAMPLE_W = 24;
  localparam int DINT_W   = 13;
  localparam int FRAC_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;

  // ring size, power of two
  localparam int DEPTH  = 8192;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [IDX_W-1:0] REG_DELAY_INT  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_DELAY_FRAC = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_GAIN       = IDX_W'(2);

  localparam logic [DINT_W-1:0] DINT_RESET = DINT_W'(1324);
  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(0);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(3277);

  // bit-serial multiplier: signed multiplicand, unsigned multiplier
  localparam int MCAND_W  = SAMPLE_W + 1;
  localparam int MPLIER_W = 16;
  localparam int HI_W     = MCAND_W + 1;
  localparam int PROD_W   = HI_W + MPLIER_W;
  localparam int CNT_W    = $clog2(MPLIER_W + 1);

  localparam int SHIFT_FRAC = 16;
  localparam int SHIFT_GAIN = 15;

  localparam int WIDE_W = SAMPLE_W + 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;

  localparam wide_t WIDE_MAX = WIDE_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam wide_t WIDE_MIN = -WIDE_W'(2 ** (SAMPLE_W - 1));

  function automatic sample_t sat_sample(input wide_t v);
    sample_t r;
    if (v > WIDE_MAX) begin
      r = sample_t'(WIDE_MAX);
    end else if (v < WIDE_MIN) begin
      r = sample_t'(WIDE_MIN);
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/fda_ram.sv
// ----------------------------------------------------------------------------
// fda_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fda_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/fda_sermul.sv
// ----------------------------------------------------------------------------
// fda_sermul
// Shift-add multiplier, one multiplier bit per cycle, exact signed product.
// ----------------------------------------------------------------------------
module fda_sermul
  import fda_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MCAND_W-1:0] mcand,
  input  logic [MPLIER_W-1:0]      mplier,
  output logic                     busy,
  output logic signed [PROD_W-1:0] product
);

  logic [CNT_W-1:0]          cnt;
  logic signed [MCAND_W-1:0] mc;
  logic signed [HI_W-1:0]    hi;
  logic [MPLIER_W-1:0]       lo;
  logic signed [HI_W:0]      sum;

  assign busy    = (cnt != '0);
  assign product = {hi, lo};
  assign sum     = {hi[HI_W-1], hi} + (lo[0] ? {{2{mc[MCAND_W-1]}}, mc} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(MPLIER_W);
      mc  <= mcand;
      hi  <= '0;
      lo  <= mplier;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      hi  <= sum[HI_W:1];
      lo  <= {sum[0], lo[MPLIER_W-1:1]};
    end
  end

endmodule

FILE: src/fractional_delay_allpass.sv
// ----------------------------------------------------------------------------
// fractional_delay_allpass
// Schroeder allpass with a linearly interpolated delay over an 8192-entry ring.
// ----------------------------------------------------------------------------
// A processed sample (action 0) is accepted and then runs three bit-serial
// multiplies (fraction blend, feedback gain, feedforward gain) on one shared
// shift-add unit, plus two reads and one write of the delay RAM, before its
// result is offered; no new sample is taken until then. A clear (action 1)
// gives no result; the ring is not swept but tracked by a write position
// and a wrapped flag, so unwritten entries read as zero and there is no
// clearing pass after reset. The next transaction is taken while a result
// still waits in the output register.
// ----------------------------------------------------------------------------
module fractional_delay_allpass
  import fda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  sample_t           sample_in,
  output logic              out_valid,
  input  logic              out_ready,
  output sample_t           sample_out
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD1   = 4'd1;
  localparam logic [3:0] S_RD2   = 4'd2;
  localparam logic [3:0] S_BLEND = 4'd3;
  localparam logic [3:0] S_M1    = 4'd4;
  localparam logic [3:0] S_GX    = 4'd5;
  localparam logic [3:0] S_M2    = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_M3    = 4'd8;

  logic [3:0]        state;
  logic [DINT_W-1:0] delay_int;
  logic [FRAC_W-1:0] delay_frac;
  logic [GAIN_W-1:0] gain;
  logic [ADDR_W-1:0] wp;
  logic              wrapped;
  logic [ADDR_W-1:0] rd_addr;
  logic              hit;
  sample_t           sample;
  sample_t           s1;
  sample_t           yd;
  sample_t           xd;

  sample_t                   rdata;
  sample_t                   s2;
  logic                      rd_hit;
  logic                      mul_start;
  logic                      mul_busy;
  logic signed [MCAND_W-1:0] mul_mcand;
  logic [MPLIER_W-1:0]       mul_mplier;
  logic signed [PROD_W-1:0]  mul_product;
  logic signed [HI_W-1:0]    blend_term;
  logic signed [HI_W-1:0]    yd_wide;
  logic signed [PROD_W-SHIFT_GAIN-1:0] gain_term;
  wide_t                     xd_wide;
  wide_t                     y_wide;
  logic                      in_fire;
  logic                      out_load;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign rd_hit   = wrapped || (rd_addr < wp);
  assign s2       = hit ? rdata : '0;

  assign blend_term = mul_product[PROD_W-1:SHIFT_FRAC];
  assign gain_term  = mul_product[PROD_W-1:SHIFT_GAIN];
  assign yd_wide    = {{(HI_W-SAMPLE_W){s1[SAMPLE_W-1]}}, s1} + blend_term;
  assign xd_wide    = {{(WIDE_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample}
                    + {{(WIDE_W-(PROD_W-SHIFT_GAIN)){gain_term[PROD_W-SHIFT_GAIN-1]}},
                       gain_term};
  assign y_wide     = {{(WIDE_W-SAMPLE_W){yd[SAMPLE_W-1]}}, yd}
                    - {{(WIDE_W-(PROD_W-SHIFT_GAIN)){gain_term[PROD_W-SHIFT_GAIN-1]}},
                       gain_term};

  assign out_load = (state == S_M3) && !mul_busy && (!out_valid || out_ready);

  always_comb begin
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    unique case (state)
      S_BLEND: begin
        mul_start  = 1'b1;
        mul_mcand  = {s2[SAMPLE_W-1], s2} - {s1[SAMPLE_W-1], s1};
        mul_mplier = delay_frac;
      end
      S_GX: begin
        mul_start  = 1'b1;
        mul_mcand  = {yd[SAMPLE_W-1], yd};
        mul_mplier = gain;
      end
      S_WR: begin
        mul_start  = 1'b1;
        mul_mcand  = {xd[SAMPLE_W-1], xd};
        mul_mplier = gain;
      end
      default: begin
      end
    endcase
  end

  fda_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (state == S_WR),
    .waddr(wp),
    .wdata(xd),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  fda_sermul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .busy   (mul_busy),
    .product(mul_product)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_int  <= DINT_RESET;
      delay_frac <= FRAC_RESET;
      gain       <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY_INT:  delay_int  <= cfg_data[DINT_W-1:0];
        REG_DELAY_FRAC: delay_frac <= cfg_data[FRAC_W-1:0];
        REG_GAIN:       gain       <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (action) begin
              wp      <= '0;
              wrapped <= 1'b0;
            end else begin
              sample  <= sample_in;
              rd_addr <= wp - ADDR_W'(delay_int);
              state   <= S_RD1;
            end
          end
        end
        S_RD1: begin
          hit     <= rd_hit;
          rd_addr <= rd_addr + ADDR_W'(1);
          state   <= S_RD2;
        end
        S_RD2: begin
          s1    <= hit ? rdata : '0;
          hit   <= rd_hit;
          state <= S_BLEND;
        end
        S_BLEND: begin
          state <= S_M1;
        end
        S_M1: begin
          if (!mul_busy) begin
            yd    <= yd_wide[SAMPLE_W-1:0];
            state <= S_GX;
          end
        end
        S_GX: begin
          state <= S_M2;
        end
        S_M2: begin
          if (!mul_busy) begin
            xd    <= sat_sample(xd_wide);
            state <= S_WR;
          end
        end
        S_WR: begin
          wp <= wp + ADDR_W'(1);
          if (wp == ADDR_W'(DEPTH - 1)) begin
            wrapped <= 1'b1;
          end
          state <= S_M3;
        end
        S_M3: begin
          if (out_load) begin
            sample_out <= sat_sample(y_wide);
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_wp_moves: assert property (@(posedge clk) disable iff (rst)
    (state != S_WR && !(in_fire && action)) |=> $stable(wp))
    else $error("write position moved outside a write or clear");

  a_mul_idle_start: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");
`endif

endmodule
